@@ src/sac_pkg.sv @@
// Shared types and constants of the shelf alignment correction block.
package sac_pkg;

    // Correction mode reported with each scan result
    typedef enum logic [1:0] {
        MODE_NONE     = 2'd0,
        MODE_COMPLEX  = 2'd1,
        MODE_TURN     = 2'd2,
        MODE_PARALLEL = 2'd3
    } mode_t;

    // Configuration register indexes (byte address is 4 * index)
    localparam logic [2:0] REG_DISTANCE_MIN = 3'd0;
    localparam logic [2:0] REG_DISTANCE_MAX = 3'd1;
    localparam logic [2:0] REG_GAIN_LATERAL = 3'd2;
    localparam logic [2:0] REG_GAIN_YAW     = 3'd3;
    localparam logic [2:0] REG_GAIN_TURN    = 3'd4;

    localparam int CFG_ADDR_W = 5;

    // Register reset values
    localparam logic [14:0]        DISTANCE_MIN_RST = 15'd0;
    localparam logic [14:0]        DISTANCE_MAX_RST = 15'd30000;
    localparam logic signed [15:0] GAIN_RST         = 16'sd256;

    // One sensor pair request
    typedef struct packed {
        logic [14:0]        left_distance;
        logic [14:0]        right_distance;
        logic signed [15:0] velocity;
        logic               last_pair;
    } sac_in_t;

    // One scan result
    typedef struct packed {
        mode_t              mode;
        logic signed [15:0] lateral_speed;
        logic signed [15:0] yaw_speed;
        logic signed [15:0] turn_angle;
    } sac_out_t;

endpackage

@@ src/shelf_alignment_correction.sv @@
// Shelf alignment correction: per-scan front/back tracking and Q8.8 correction outputs.
//
// A scan is a run of sensor-pair requests closed by one with last_pair set. A reading
// counts when it lies strictly between distance_min and distance_max; per side the first
// such reading is kept as front and the latest as back. Every request is taken into an
// input register and processed from there, so one request is accepted per clock unless
// stalled; only the closing request of a scan yields a result, loaded into the result
// register at the clock edge after its acceptance at the earliest. The request path stalls
// only while a closing request waits on a held result that the downstream side is not
// ready to take. The user must write configuration over the APB port only while the
// block is idle (not enforced by the block); reads return the current register values.
module shelf_alignment_correction #(
    parameter int DIST_WIDTH = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // sensor pair requests
    input  logic                             s_valid,
    output logic                             s_ready,
    input  sac_pkg::sac_in_t                 s_item,
    // scan results
    output logic                             m_valid,
    input  logic                             m_ready,
    output sac_pkg::sac_out_t                m_result,
    // configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [sac_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import sac_pkg::*;

    localparam int OP_W   = DIST_WIDTH + 2;
    localparam int PROD_W = OP_W + 16;

    // Configuration registers
    logic [14:0]        dist_min_reg;
    logic [14:0]        dist_max_reg;
    logic signed [15:0] gain_lat_reg;
    logic signed [15:0] gain_yaw_reg;
    logic signed [15:0] gain_turn_reg;

    // Input and result stages
    logic     in_v_reg;
    sac_in_t  in_reg;
    logic     out_v_reg;
    sac_out_t out_reg;

    // Scan state
    logic [1:0]            lcnt_reg, rcnt_reg;
    logic [DIST_WIDTH-1:0] lfront_reg, lback_reg, rfront_reg, rback_reg;
    logic [DIST_WIDTH-1:0] first_l_reg, first_r_reg;
    logic                  scan_start_reg;

    logic [1:0]            lcnt_next, rcnt_next;
    logic [DIST_WIDTH-1:0] lfront_next, lback_next, rfront_next, rback_next;
    logic [DIST_WIDTH-1:0] first_l_next, first_r_next;

    logic                  cfg_we;
    logic [2:0]            cfg_idx;
    logic                  fire;
    logic                  out_free;
    logic [DIST_WIDTH-1:0] ld_m, rd_m;
    logic                  l_ok, r_ok;
    logic [1:0]            lcnt_base, rcnt_base;
    logic                  first_ok, last_ok;
    mode_t                 mode_sel;
    logic signed [OP_W-1:0]   lf_s, lb_s, rf_s, rb_s;
    logic signed [OP_W-1:0]   lat_op, yaw_op, turn_op;
    logic signed [PROD_W-1:0] lat_prod, yaw_prod, turn_prod, lat_adj;
    sac_out_t              res;

    // Clamp a wide product into signed 16 bits
    function automatic logic signed [15:0] sat16(input logic signed [PROD_W-1:0] v);
        logic all_one, all_zero;
        all_one  = &v[PROD_W-1:15];
        all_zero = ~|v[PROD_W-1:15];
        if (all_one || all_zero) begin
            return v[15:0];
        end else if (v[PROD_W-1]) begin
            return 16'sh8000;
        end else begin
            return 16'sh7fff;
        end
    endfunction

    // APB access
    assign pready  = 1'b1;
    assign cfg_idx = paddr[CFG_ADDR_W-1:2];
    assign cfg_we  = psel && penable && pwrite;

    always_comb begin
        case (cfg_idx)
            REG_DISTANCE_MIN: prdata = 32'(dist_min_reg);
            REG_DISTANCE_MAX: prdata = 32'(dist_max_reg);
            REG_GAIN_LATERAL: prdata = 32'(gain_lat_reg);
            REG_GAIN_YAW:     prdata = 32'(gain_yaw_reg);
            REG_GAIN_TURN:    prdata = 32'(gain_turn_reg);
            default:          prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dist_min_reg  <= DISTANCE_MIN_RST;
            dist_max_reg  <= DISTANCE_MAX_RST;
            gain_lat_reg  <= GAIN_RST;
            gain_yaw_reg  <= GAIN_RST;
            gain_turn_reg <= GAIN_RST;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                REG_DISTANCE_MIN: dist_min_reg  <= pwdata[14:0];
                REG_DISTANCE_MAX: dist_max_reg  <= pwdata[14:0];
                REG_GAIN_LATERAL: gain_lat_reg  <= signed'(pwdata[15:0]);
                REG_GAIN_YAW:     gain_yaw_reg  <= signed'(pwdata[15:0]);
                REG_GAIN_TURN:    gain_turn_reg <= signed'(pwdata[15:0]);
                default: ;
            endcase
        end
    end

    // Handshake: a non-closing request always retires; a closing one needs the result slot
    assign out_free = !out_v_reg || m_ready;
    assign fire     = in_v_reg && (!in_reg.last_pair || out_free);
    assign s_ready  = !in_v_reg || fire;
    assign m_valid  = out_v_reg;
    assign m_result = out_reg;

    // Reading validity and stored width
    assign ld_m = DIST_WIDTH'(32'(in_reg.left_distance));
    assign rd_m = DIST_WIDTH'(32'(in_reg.right_distance));
    assign l_ok = (in_reg.left_distance > dist_min_reg) && (in_reg.left_distance < dist_max_reg);
    assign r_ok = (in_reg.right_distance > dist_min_reg) && (in_reg.right_distance < dist_max_reg);

    // Front/back tracking per side
    always_comb begin
        lcnt_base    = scan_start_reg ? 2'd0 : lcnt_reg;
        rcnt_base    = scan_start_reg ? 2'd0 : rcnt_reg;
        first_l_next = scan_start_reg ? ld_m : first_l_reg;
        first_r_next = scan_start_reg ? rd_m : first_r_reg;
        lcnt_next    = lcnt_base;
        lfront_next  = lfront_reg;
        lback_next   = lback_reg;
        rcnt_next    = rcnt_base;
        rfront_next  = rfront_reg;
        rback_next   = rback_reg;
        if (l_ok) begin
            if (lcnt_base == 2'd0) begin
                lfront_next = ld_m;
                lcnt_next   = 2'd1;
            end else begin
                lcnt_next = 2'd2;
            end
            lback_next = ld_m;
        end
        if (r_ok) begin
            if (rcnt_base == 2'd0) begin
                rfront_next = rd_m;
                rcnt_next   = 2'd1;
            end else begin
                rcnt_next = 2'd2;
            end
            rback_next = rd_m;
        end
    end

    // Mode choice on the closing pair
    assign first_ok = (33'(first_l_next) < 33'(dist_max_reg))
                   && (33'(first_r_next) < 33'(dist_max_reg));
    assign last_ok  = (33'(ld_m) < 33'(dist_max_reg)) && (33'(rd_m) < 33'(dist_max_reg));

    assign lf_s = signed'(OP_W'(lfront_next));
    assign lb_s = signed'(OP_W'(lback_next));
    assign rf_s = signed'(OP_W'(rfront_next));
    assign rb_s = signed'(OP_W'(rback_next));

    always_comb begin
        mode_sel = MODE_NONE;
        lat_op   = '0;
        yaw_op   = '0;
        turn_op  = '0;
        if (in_reg.velocity != 16'sd0) begin
            if (lcnt_next == 2'd2 && rcnt_next == 2'd2) begin
                mode_sel = MODE_COMPLEX;
                lat_op   = (rf_s + rb_s) - (lf_s + lb_s);
                yaw_op   = lf_s - lb_s;
            end else if (lcnt_next != 2'd0 && rcnt_next != 2'd0) begin
                if (!in_reg.velocity[15]) begin
                    // forward
                    if (first_ok) begin
                        mode_sel = MODE_TURN;
                        turn_op  = rf_s - lf_s;
                    end else if (last_ok) begin
                        mode_sel = MODE_PARALLEL;
                        lat_op   = rb_s - lb_s;
                    end
                end else begin
                    // backward
                    if (first_ok) begin
                        mode_sel = MODE_PARALLEL;
                        lat_op   = rf_s - lf_s;
                    end else if (last_ok) begin
                        mode_sel = MODE_TURN;
                        turn_op  = rb_s - lb_s;
                    end
                end
            end
        end
    end

    // Gain scaling; the complex lateral term is a doubled average, halved toward minus infinity
    assign lat_prod  = lat_op * gain_lat_reg;
    assign yaw_prod  = yaw_op * gain_yaw_reg;
    assign turn_prod = turn_op * gain_turn_reg;
    assign lat_adj   = (mode_sel == MODE_COMPLEX) ? (lat_prod >>> 1) : lat_prod;

    always_comb begin
        res.mode          = mode_sel;
        res.lateral_speed = sat16(lat_adj);
        res.yaw_speed     = sat16(yaw_prod);
        res.turn_angle    = sat16(turn_prod);
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg <= 1'b0;
        end else if (s_ready) begin
            in_v_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_item;
        end
    end

    // Scan state update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lcnt_reg       <= 2'd0;
            rcnt_reg       <= 2'd0;
            scan_start_reg <= 1'b1;
        end else if (fire) begin
            lcnt_reg       <= lcnt_next;
            rcnt_reg       <= rcnt_next;
            scan_start_reg <= in_reg.last_pair;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            lfront_reg  <= lfront_next;
            lback_reg   <= lback_next;
            rfront_reg  <= rfront_next;
            rback_reg   <= rback_next;
            first_l_reg <= first_l_next;
            first_r_reg <= first_r_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (fire && in_reg.last_pair) begin
            out_v_reg <= 1'b1;
        end else if (m_ready) begin
            out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && in_reg.last_pair) begin
            out_reg <= res;
        end
    end

endmodule
